[src/cha_pkg.sv]
// ----------------------------------------------------------------------------
// cha_pkg: shared types and constants for the compass heading block
// Holds the CORDIC angle table, the front-to-back word type and state codes.
// ----------------------------------------------------------------------------
package cha_pkg;

   localparam int TAB_LEN = 24;
   localparam int ANG_W   = 27;   // degrees with 16 fraction bits, +/-2^26

   // atan(2^-i) in degrees, 16 fraction bits
   function automatic logic [ANG_W-1:0] atan_tab(input logic [4:0] idx);
      logic [ANG_W-1:0] v;
      case (idx)
         5'd0:  v = 27'd2949120;
         5'd1:  v = 27'd1740967;
         5'd2:  v = 27'd919879;
         5'd3:  v = 27'd466945;
         5'd4:  v = 27'd234379;
         5'd5:  v = 27'd117304;
         5'd6:  v = 27'd58666;
         5'd7:  v = 27'd29335;
         5'd8:  v = 27'd14668;
         5'd9:  v = 27'd7334;
         5'd10: v = 27'd3667;
         5'd11: v = 27'd1833;
         5'd12: v = 27'd917;
         5'd13: v = 27'd458;
         5'd14: v = 27'd229;
         5'd15: v = 27'd115;
         5'd16: v = 27'd57;
         5'd17: v = 27'd29;
         5'd18: v = 27'd14;
         5'd19: v = 27'd7;
         5'd20: v = 27'd4;
         5'd21: v = 27'd2;
         5'd22: v = 27'd1;
         default: v = 27'd0;
      endcase
      return v;
   endfunction

   // Classified word from front to back
   typedef struct packed {
      logic               valid_span;  // sample word with both spans nonzero
      logic signed [16:0] xc;          // recentered samples
      logic signed [16:0] yc;
      logic        [16:0] xspan;
      logic        [16:0] yspan;
   } work_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_DIV, ST_PREP, ST_ROT, ST_FIN, ST_OUT
   } back_state_type;

endpackage

[src/compass_heading_autocal.sv]
// ----------------------------------------------------------------------------
// compass_heading_autocal: magnetometer heading with min/max self calibration
// Tracks X/Y bounds, recenters and scales each sample, and gives atan2 heading.
// ----------------------------------------------------------------------------
//  channel | dir | tdata fields (low bit up)            | tuser
//  req_    | in  | mag_x[15:0], mag_y[31:16]            | action
//  rsp_    | out | heading_deg[8:0], heading_valid[9]   | -
//
//  A sample word passes through the divide (both axes side by side), the
//  CORDIC rotation steps and the prep, finish and output states. Clear
//  words and zero-span samples go straight from idle to output.
//  A finished heading waits in a staging register until the output register
//  is free; the engine stays in its output state meanwhile and takes no new word.
//  The front updates bounds as each word is taken and queues two words ahead,
//  so the sender stalls only when the back engine is busy and the queue is full.
//  Reset is synchronous and clears bounds, queue and result valid.
// ----------------------------------------------------------------------------
module compass_heading_autocal #(
   parameter int QUOT_FRAC_BITS = 16,
   parameter int CORDIC_STEPS   = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // mag_x, mag_y
   input  logic        req_tuser,   // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // heading_deg, heading_valid
);
   import cha_pkg::*;

   logic     f_valid, f_ready, b_valid, b_ready;
   work_type f_work, b_work;
   logic [8:0] deg;
   logic       hv;

   cha_front u_front (
      .clock, .reset,
      .in_valid (req_tvalid), .in_ready (req_tready),
      .in_action(req_tuser),
      .in_x     (signed'(req_tdata[15:0])),
      .in_y     (signed'(req_tdata[31:16])),
      .out_valid(f_valid), .out_ready(f_ready), .out_work(f_work)
   );

   cha_fifo u_fifo (
      .clock, .reset,
      .wr_valid(f_valid), .wr_ready(f_ready), .wr_work(f_work),
      .rd_valid(b_valid), .rd_ready(b_ready), .rd_work(b_work)
   );

   cha_back #(.QFB(QUOT_FRAC_BITS), .STEPS(CORDIC_STEPS)) u_back (
      .clock, .reset,
      .in_valid (b_valid), .in_ready (b_ready), .in_work(b_work),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_deg  (deg), .out_hvalid(hv)
   );

   assign rsp_tdata = {6'd0, hv, deg};

endmodule

[src/cha_front.sv]
// ----------------------------------------------------------------------------
// cha_front: bound tracking and recentering
// Accepts input words, updates min/max bounds and emits classified work words.
// ----------------------------------------------------------------------------
module cha_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic                in_action,
   input  logic signed [15:0]  in_x,
   input  logic signed [15:0]  in_y,
   output logic                out_valid,
   input  logic                out_ready,
   output cha_pkg::work_type   out_work
);
   import cha_pkg::*;

   logic signed [15:0] xmin_ff, xmax_ff, ymin_ff, ymax_ff;
   logic signed [15:0] xmin_in, xmax_in, ymin_in, ymax_in;
   logic               vld_ff;
   work_type           work_ff, work_in;
   logic signed [16:0] xsum, ysum, xmid, ymid;
   logic        [16:0] xsp, ysp;

   assign in_ready  = !vld_ff || out_ready;
   assign out_valid = vld_ff;
   assign out_work  = work_ff;

   always_comb begin
      xmin_in = (in_x < xmin_ff) ? in_x : xmin_ff;
      xmax_in = (in_x > xmax_ff) ? in_x : xmax_ff;
      ymin_in = (in_y < ymin_ff) ? in_y : ymin_ff;
      ymax_in = (in_y > ymax_ff) ? in_y : ymax_ff;
      xsp  = 17'(signed'({xmax_in[15], xmax_in}) - signed'({xmin_in[15], xmin_in}));
      ysp  = 17'(signed'({ymax_in[15], ymax_in}) - signed'({ymin_in[15], ymin_in}));
      xsum = 17'(signed'({xmax_in[15], xmax_in}) + signed'({xmin_in[15], xmin_in}));
      ysum = 17'(signed'({ymax_in[15], ymax_in}) + signed'({ymin_in[15], ymin_in}));
      // divide by two truncated toward zero
      xmid = (xsum + signed'(17'(xsum[16]))) >>> 1;
      ymid = (ysum + signed'(17'(ysum[16]))) >>> 1;
      work_in.valid_span = !in_action && (xsp != 17'd0) && (ysp != 17'd0);
      work_in.xc    = 17'({in_x[15], in_x} - xmid);
      work_in.yc    = 17'({in_y[15], in_y} - ymid);
      work_in.xspan = xsp;
      work_in.yspan = ysp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= 1'b0;
         xmin_ff <= '0;
         xmax_ff <= '0;
         ymin_ff <= '0;
         ymax_ff <= '0;
      end else begin
         if (out_ready) vld_ff <= 1'b0;
         if (in_valid && in_ready) begin
            vld_ff <= 1'b1;
            if (in_action) begin
               xmin_ff <= '0;
               xmax_ff <= '0;
               ymin_ff <= '0;
               ymax_ff <= '0;
            end else begin
               xmin_ff <= xmin_in;
               xmax_ff <= xmax_in;
               ymin_ff <= ymin_in;
               ymax_ff <= ymax_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) work_ff <= work_in;
   end

endmodule

[src/cha_fifo.sv]
// ----------------------------------------------------------------------------
// cha_fifo: two-entry queue between front and back
// Decouples the bound tracker from the divide/CORDIC engine.
// ----------------------------------------------------------------------------
module cha_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_valid,
   output logic               wr_ready,
   input  cha_pkg::work_type  wr_work,
   output logic               rd_valid,
   input  logic               rd_ready,
   output cha_pkg::work_type  rd_work
);
   import cha_pkg::*;

   work_type   mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       wr_go, rd_go;

   assign wr_ready = (cnt_ff != 2'd2);
   assign rd_valid = (cnt_ff != 2'd0);
   assign rd_work  = mem_ff[rp_ff];
   assign wr_go    = wr_valid && wr_ready;
   assign rd_go    = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (wr_go) wp_ff <= !wp_ff;
         if (rd_go) rp_ff <= !rp_ff;
         cnt_ff <= 2'(cnt_ff + 2'(wr_go) - 2'(rd_go));
      end
   end

   always_ff @(posedge clock) begin
      if (wr_go) mem_ff[wp_ff] <= wr_work;
   end

endmodule

[src/cha_back.sv]
// ----------------------------------------------------------------------------
// cha_back: scaled quotients, CORDIC atan2 and heading wrap
// Restoring dividers for both axes in parallel, then a shared CORDIC step.
// ----------------------------------------------------------------------------
module cha_back #(
   parameter int QFB   = 16,
   parameter int STEPS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  cha_pkg::work_type  in_work,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [8:0]         out_deg,
   output logic               out_hvalid
);
   import cha_pkg::*;

   localparam int QW  = 17 + QFB;        // quotient magnitude width
   localparam int CW  = QW + 3;          // CORDIC datapath width
   localparam int NST = (STEPS < TAB_LEN) ? STEPS : TAB_LEN;
   localparam int DCW = $clog2(QW + 1);

   back_state_type st_ff, st_in;
   logic [DCW-1:0] dcnt_ff, dcnt_in;
   logic [4:0]     icnt_ff, icnt_in;
   logic [QW-1:0]  xr_ff, yr_ff, xq_ff, yq_ff;  // remainder, quotient
   logic [QW-1:0]  xr_in, yr_in, xq_in, yq_in;
   logic [16:0]    xd_ff, yd_ff;
   logic           xn_ff, yn_ff, hv_ff, hv_in;
   logic [QW-1:0]  xm_ff, ym_ff, xm_in, ym_in;  // magnitudes shifted out
   logic signed [CW-1:0]    cx_ff, cy_ff, cx_in, cy_in;
   logic signed [ANG_W-1:0] z_ff, z_in;
   logic [8:0]     deg_ff, deg_in;
   logic [8:0]     rdeg_ff, rdeg_in;            // finished heading, staged
   logic           rhv_ff, rhv_in;
   logic           ov_ff, ov_in;
   logic [QW:0]    xt, yt;
   logic signed [CW-1:0] qx, qy, dx, dy;
   logic signed [ANG_W-1:0] zt;
   logic signed [11:0] h;

   assign in_ready   = (st_ff == ST_IDLE);
   assign out_valid  = ov_ff;
   assign out_deg    = deg_ff;
   assign out_hvalid = hv_ff;

   always_comb begin
      st_in = st_ff;  dcnt_in = dcnt_ff;  icnt_in = icnt_ff;
      xr_in = xr_ff;  yr_in = yr_ff;  xq_in = xq_ff;  yq_in = yq_ff;
      xm_in = xm_ff;  ym_in = ym_ff;
      cx_in = cx_ff;  cy_in = cy_ff;  z_in = z_ff;
      deg_in = deg_ff; hv_in = hv_ff; ov_in = ov_ff;
      rdeg_in = rdeg_ff; rhv_in = rhv_ff;
      xt = '0; yt = '0; qx = '0; qy = '0; dx = '0; dy = '0; zt = '0; h = '0;
      if (ov_ff && out_ready) ov_in = 1'b0;
      case (st_ff)
         ST_IDLE: begin
            if (in_valid) begin
               // magnitude << QFB shifted in MSB first
               xm_in = QW'(in_work.xc[16] ? -in_work.xc : in_work.xc) << QFB;
               ym_in = QW'(in_work.yc[16] ? -in_work.yc : in_work.yc) << QFB;
               xr_in = '0; yr_in = '0; xq_in = '0; yq_in = '0;
               dcnt_in = '0;
               if (in_work.valid_span) begin
                  st_in = ST_DIV;
               end else begin
                  rdeg_in = '0; rhv_in = 1'b0;
                  st_in = ST_OUT;
               end
            end
         end
         ST_DIV: begin
            xt = {xr_ff, xm_ff[QW-1]};
            yt = {yr_ff, ym_ff[QW-1]};
            xm_in = xm_ff << 1;
            ym_in = ym_ff << 1;
            if (xt >= (QW+1)'(xd_ff)) begin
               xr_in = QW'(xt - (QW+1)'(xd_ff)); xq_in = {xq_ff[QW-2:0], 1'b1};
            end else begin
               xr_in = QW'(xt); xq_in = {xq_ff[QW-2:0], 1'b0};
            end
            if (yt >= (QW+1)'(yd_ff)) begin
               yr_in = QW'(yt - (QW+1)'(yd_ff)); yq_in = {yq_ff[QW-2:0], 1'b1};
            end else begin
               yr_in = QW'(yt); yq_in = {yq_ff[QW-2:0], 1'b0};
            end
            dcnt_in = DCW'(dcnt_ff + 1'b1);
            if (dcnt_ff == DCW'(QW - 1)) st_in = ST_PREP;
         end
         ST_PREP: begin
            qx = xn_ff ? -CW'(xq_ff) : CW'(xq_ff);
            qy = yn_ff ? -CW'(yq_ff) : CW'(yq_ff);
            icnt_in = '0;
            st_in = ST_ROT;
            if (qy == 0) begin
               z_in = qx < 0 ? ANG_W'(180 * 65536) : '0;
               st_in = ST_FIN;
            end else if (qx == 0) begin
               z_in = qy > 0 ? ANG_W'(90 * 65536) : -ANG_W'(90 * 65536);
               st_in = ST_FIN;
            end else if (qx < 0) begin
               if (qy > 0) begin
                  cx_in = qy; cy_in = -qx; z_in = ANG_W'(90 * 65536);
               end else begin
                  cx_in = -qy; cy_in = qx; z_in = -ANG_W'(90 * 65536);
               end
            end else begin
               cx_in = qx; cy_in = qy; z_in = '0;
            end
         end
         ST_ROT: begin
            dx = cy_ff >>> icnt_ff;
            dy = cx_ff >>> icnt_ff;
            if (cy_ff > 0) begin
               cx_in = cx_ff + dx; cy_in = cy_ff - dy;
               z_in  = z_ff + signed'(atan_tab(icnt_ff));
            end else begin
               cx_in = cx_ff - dx; cy_in = cy_ff + dy;
               z_in  = z_ff - signed'(atan_tab(icnt_ff));
            end
            icnt_in = 5'(icnt_ff + 1'b1);
            if (icnt_ff == 5'(NST - 1)) st_in = ST_FIN;
         end
         ST_FIN: begin
            // truncate toward zero to whole degrees, clamp, wrap
            zt = z_ff < 0 ? -z_ff : z_ff;
            h  = 12'(zt >>> 16);
            if (z_ff < 0) h = -h;
            if (h > 12'sd180) h = 12'sd180;
            if (h < -12'sd180) h = -12'sd180;
            if (h <= 0) h = h + 12'sd360;
            rdeg_in = 9'(h);
            rhv_in  = 1'b1;
            st_in   = ST_OUT;
         end
         ST_OUT: begin
            // output register only loads once the previous word has left
            if (!ov_ff || out_ready) begin
               ov_in  = 1'b1;
               deg_in = rdeg_ff;
               hv_in  = rhv_ff;
               st_in  = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         ov_ff <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      dcnt_ff <= dcnt_in; icnt_ff <= icnt_in;
      xr_ff <= xr_in; yr_ff <= yr_in; xq_ff <= xq_in; yq_ff <= yq_in;
      xm_ff <= xm_in; ym_ff <= ym_in;
      cx_ff <= cx_in; cy_ff <= cy_in; z_ff <= z_in;
      deg_ff <= deg_in; hv_ff <= hv_in;
      rdeg_ff <= rdeg_in; rhv_ff <= rhv_in;
      if (st_ff == ST_IDLE && in_valid) begin
         xd_ff <= in_work.xspan;
         yd_ff <= in_work.yspan;
         xn_ff <= in_work.xc[16];
         yn_ff <= in_work.yc[16];
      end
   end

endmodule

[dv/heading_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// heading_checker: scoreboard for the compass heading block
// Watches both stream channels, predicts each heading from the learned
// min/max bounds and compares every response word in order.
// ----------------------------------------------------------------------------
module heading_checker #(
   parameter int QFB   = 16,
   parameter int STEPS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,
   output int          fail_count,
   output int          pending
);
   import cha_pkg::*;

   typedef struct packed {
      logic [8:0] deg;
      logic       ok;
   } heading_word_type;

   localparam logic ACT_CLEAR  = 1'b1;
   localparam longint DEG_ONE  = 65536;

   heading_word_type expected_headings[$];
   int x_lo, x_hi, y_lo, y_hi;

   function automatic longint angle_table(int i);
      case (i)
         0:  return 2949120;
         1:  return 1740967;
         2:  return 919879;
         3:  return 466945;
         4:  return 234379;
         5:  return 117304;
         6:  return 58666;
         7:  return 29335;
         8:  return 14668;
         9:  return 7334;
         10: return 3667;
         11: return 1833;
         12: return 917;
         13: return 458;
         14: return 229;
         15: return 115;
         16: return 57;
         17: return 29;
         18: return 14;
         19: return 7;
         20: return 4;
         21: return 2;
         22: return 1;
         default: return 0;
      endcase
   endfunction

   // Q2.QFB quotient, magnitude divided, sign restored (truncates toward zero)
   function automatic longint unit_quot(int num, int den);
      longint m;
      longint q;
      m = (num < 0) ? -longint'(num) : longint'(num);
      q = (m <<< QFB) / den;
      return (num < 0) ? -q : q;
   endfunction

   function automatic longint vector_angle(longint qx, longint qy);
      longint z;
      longint t;
      longint dx;
      longint dy;
      z = 0;
      if (qy == 0) return (qx < 0) ? 180 * DEG_ONE : 0;
      if (qx == 0) return (qy > 0) ? 90 * DEG_ONE : -90 * DEG_ONE;
      // pre-rotate left half plane into the right one
      if (qx < 0) begin
         if (qy > 0) begin
            t = qx; qx = qy; qy = -t; z = 90 * DEG_ONE;
         end else begin
            t = qx; qx = -qy; qy = t; z = -90 * DEG_ONE;
         end
      end
      for (int i = 0; i < STEPS && i < TAB_LEN; i++) begin
         dx = qy >>> i;
         dy = qx >>> i;
         if (qy > 0) begin
            qx += dx; qy -= dy; z += angle_table(i);
         end else begin
            qx -= dx; qy += dy; z -= angle_table(i);
         end
      end
      return z;
   endfunction

   function automatic heading_word_type predict_heading(logic act, logic signed [15:0] mx,
                                                        logic signed [15:0] my);
      heading_word_type r;
      int x;
      int y;
      int xs;
      int ys;
      longint z;
      longint h;
      r = '0;
      if (act == ACT_CLEAR) begin
         x_lo = 0; x_hi = 0; y_lo = 0; y_hi = 0;
         return r;
      end
      x = mx;
      y = my;
      if (x < x_lo) x_lo = x;
      if (x > x_hi) x_hi = x;
      if (y < y_lo) y_lo = y;
      if (y > y_hi) y_hi = y;
      xs = x_hi - x_lo;
      ys = y_hi - y_lo;
      if (xs == 0 || ys == 0) return r;
      z = vector_angle(unit_quot(x - (x_hi + x_lo) / 2, xs),
                       unit_quot(y - (y_hi + y_lo) / 2, ys));
      h = (z < 0) ? -((-z) >> 16) : (z >> 16);
      if (h > 180) h = 180;
      if (h < -180) h = -180;
      if (h <= 0) h += 360;
      r.deg = h[8:0];
      r.ok  = 1'b1;
      return r;
   endfunction

   task automatic report_mismatch(string what);
      $display("mismatch at %0t: %s", $time, what);
      fail_count++;
   endtask

   assign pending = expected_headings.size();

   initial fail_count = 0;

   always @(posedge clock) begin
      heading_word_type got;
      heading_word_type want;
      if (reset) begin
         x_lo <= 0; x_hi <= 0; y_lo <= 0; y_hi <= 0;
      end else begin
         if (req_tvalid && req_tready)
            expected_headings.push_back(predict_heading(req_tuser, req_tdata[15:0],
                                                        req_tdata[31:16]));
         if (rsp_tvalid && rsp_tready) begin
            // heading_deg in bits 8:0, heading_valid in bit 9
            got = {rsp_tdata[8:0], rsp_tdata[9]};
            if (expected_headings.size() == 0) begin
               report_mismatch("response word with nothing expected");
            end else begin
               want = expected_headings.pop_front();
               if (got.ok !== want.ok)
                  report_mismatch($sformatf("heading_valid %0b, want %0b", got.ok, want.ok));
               if (got.deg !== want.deg)
                  report_mismatch($sformatf("heading_deg %0d, want %0d", got.deg, want.deg));
            end
         end
      end
   end

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for compass_heading_autocal
// Drives directed and random sample/clear words through three idling
// phases; the checker predicts and compares every heading.
// ----------------------------------------------------------------------------
module testbench;
   localparam logic ACT_SAMPLE = 1'b0;
   localparam logic ACT_CLEAR  = 1'b1;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // mag_x[15:0], mag_y[31:16]
   logic        req_tuser = 1'b0; // action
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // heading_deg[8:0], heading_valid[9]
   int          fail_count;
   int          pending;
   int          send_idle_pct;
   int          recv_idle_pct;

   always #10 clock = ~clock;

   compass_heading_autocal u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   heading_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .fail_count(fail_count), .pending(pending)
   );

   // receiver stall, redrawn every falling edge
   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   // one word; random sender gaps before it, held until accepted.
   // tvalid stays high on return so the next word can follow directly.
   task automatic send_word(logic act, logic [15:0] mx, logic [15:0] my);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {my, mx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // mostly a rotating field around a random hard-iron offset
   task automatic random_word();
      int r;
      int ox;
      int oy;
      int rad;
      real a;
      r = $urandom_range(99);
      if (r < 3) begin
         send_word(ACT_CLEAR, 16'($urandom), 16'($urandom));
      end else if (r < 20) begin
         send_word(ACT_SAMPLE, 16'($urandom), 16'($urandom));
      end else begin
         ox  = $urandom_range(8000) - 4000;
         oy  = $urandom_range(8000) - 4000;
         rad = $urandom_range(20000) + 10;
         a   = $urandom_range(3599) * 3.14159265 / 1800.0;
         send_word(ACT_SAMPLE, 16'(ox + $rtoi(rad * $cos(a))),
                   16'(oy + $rtoi(rad * $sin(a))));
      end
   endtask

   initial begin
      send_idle_pct = 14;
      recv_idle_pct = 86;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // zero span, extremes, exact axes, clear with junk fields
      send_word(ACT_SAMPLE, 16'h0000, 16'h0000);
      send_word(ACT_SAMPLE, 16'h0100, 16'h0000);
      send_word(ACT_SAMPLE, 16'h7FFF, 16'h7FFF);
      send_word(ACT_SAMPLE, 16'h8000, 16'h8000);
      send_word(ACT_SAMPLE, 16'hFFFF, 16'hFFFF);
      send_word(ACT_SAMPLE, 16'h0000, 16'h7FFF);
      send_word(ACT_SAMPLE, 16'h0000, 16'h8000);
      send_word(ACT_SAMPLE, 16'h7FFF, 16'hFFFF);
      send_word(ACT_SAMPLE, 16'h8000, 16'hFFFF);
      send_word(ACT_SAMPLE, 16'h8000, 16'h0000);
      send_word(ACT_CLEAR,  16'hFFFF, 16'hFFFF);
      send_word(ACT_SAMPLE, 16'h0010, 16'h0010);
      send_word(ACT_SAMPLE, 16'hFFF0, 16'hFFF0);
      send_word(ACT_SAMPLE, 16'h0000, 16'h0010);
      send_word(ACT_SAMPLE, 16'hFFF0, 16'h0000);
      send_word(ACT_SAMPLE, 16'h0010, 16'h0000);
      send_word(ACT_SAMPLE, 16'h0000, 16'hFFF0);
      send_word(ACT_SAMPLE, 16'hFFF0, 16'h0010);
      send_word(ACT_SAMPLE, 16'h5555, 16'hAAAA);
      send_word(ACT_SAMPLE, 16'hAAAA, 16'h5555);
      send_word(ACT_CLEAR,  16'h0000, 16'h0000);

      // hold off until the pipe drains
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);

      for (int i = 0; i < 1200; i++) begin
         if (i == 400) begin
            send_idle_pct = 86;
            recv_idle_pct = 14;
         end else if (i == 800) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         random_word();
      end

      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // generous cap: 1221 words plus heavy stalls
   initial begin
      #40ms;
      $display("status: fail");
      $finish;
   end

endmodule
